>>> hw/rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Cell layout, item modes, datapath operations and control/status bundles.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_ROWS = 25;
	localparam int DEF_COLS = 80;

	localparam int MODE_W   = 2;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int OCOL_W   = 7;
	localparam int OROW_W   = 5;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] LINE_FEED    = 8'd10;
	localparam logic [CHAR_W-1:0] CARRIAGE_RET = 8'd13;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUT,
		OP_COPY,
		OP_BLANK,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic put_scroll;
		logic copy_end;
		logic sweep_end;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer for the text console
// Takes one item at a time and walks the datapath through put, read,
// scroll copy, blank sweep and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	input  wire logic [tcw_pkg::MODE_W-1:0] in_mode,
	output logic                            s_tready,
	output tcw_pkg::cmd_t                   cmd,
	input  wire tcw_pkg::stat_t             status
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op = OP_LOAD;
					case (in_mode)
						MODE_PUT:   state_nx = ST_PUT;
						MODE_CLEAR: state_nx = ST_BLANK;
						MODE_READ:  state_nx = ST_READ;
						default:    state_nx = ST_FINISH;
					endcase
				end
			end
			ST_PUT: begin
				cmd.op   = OP_PUT;
				state_nx = status.put_scroll ? ST_COPY : ST_FINISH;
			end
			ST_READ: begin
				state_nx = ST_FINISH;
			end
			ST_COPY: begin
				cmd.op = OP_COPY;
				if (status.copy_end) begin
					state_nx = ST_DRAIN;
				end
			end
			// last copied cell is still being written back
			ST_DRAIN: begin
				state_nx = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.op = OP_BLANK;
				if (status.sweep_end) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.op   = OP_OUT;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE)
		else $error("tcw_ctrl: accepted beat did not start work");

	a_out_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> status.out_free)
		else $error("tcw_ctrl: result loaded over a pending beat");

	a_copy_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_COPY |=> cmd.op == OP_COPY || state_q == ST_DRAIN)
		else $error("tcw_ctrl: scroll copy broken off");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and result register
// One-write one-read cell memory with registered read data, sweep pointer,
// cursor update and the output beat register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int ROWS = tcw_pkg::DEF_ROWS,
	parameter int COLS = tcw_pkg::DEF_COLS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_wdata,
	input  wire logic [tcw_pkg::MODE_W-1:0]   in_mode,
	input  wire logic [tcw_pkg::CHAR_W-1:0]   in_char,
	input  wire logic [tcw_pkg::IDX_W-1:0]    in_idx,
	input  wire tcw_pkg::cmd_t                cmd,
	output tcw_pkg::stat_t                    status,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [tcw_pkg::M_DATA_W-1:0]      out_data
);
	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLS;
	localparam int CELL_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int WORD_W = CHAR_W + ATTR_W;

	localparam logic [CELL_W-1:0] COLS_C     = CELL_W'(COLS);
	localparam logic [CELL_W-1:0] COPY_LAST  = CELL_W'((ROWS - 1) * COLS - 1);
	localparam logic [CELL_W-1:0] SWEEP_LAST = CELL_W'(CELLS - 1);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	logic [WORD_W-1:0] mem [CELLS];

	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [MODE_W-1:0] mode_q;
	logic [CHAR_W-1:0] char_q;
	logic [IDX_W-1:0]  idx_q;
	logic              rd_ok_q;
	logic              scroll_q;
	logic [CELL_W-1:0] ptr_q;
	logic              copy_pend_q;
	logic [CELL_W-1:0] copy_addr_q;
	logic [WORD_W-1:0] rd_q;

	logic              out_valid_q;
	logic [OCOL_W-1:0] out_col_q;
	logic [OROW_W-1:0] out_row_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [ATTR_W-1:0] out_attr_q;
	logic              out_scroll_q;

	logic              is_nl;
	logic              wrap;
	logic [CELL_W-1:0] put_addr;
	logic              we;
	logic [CELL_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic [CELL_W-1:0] raddr;
	logic              show_cell;

	assign is_nl    = (char_q == LINE_FEED) || (char_q == CARRIAGE_RET);
	assign wrap     = is_nl || (col_q == COL_LAST);
	assign put_addr = CELL_W'(row_q) * COLS_C + CELL_W'(col_q);
	assign raddr    = (cmd.op == OP_COPY) ? ptr_q + COLS_C : CELL_W'(idx_q);

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = {attr_q, BLANK_CHAR};
		if (copy_pend_q) begin
			we    = 1'b1;
			waddr = copy_addr_q;
			wdata = rd_q;
		end else if (cmd.op == OP_PUT && !is_nl) begin
			we    = 1'b1;
			waddr = put_addr;
			wdata = {attr_q, char_q};
		end else if (cmd.op == OP_BLANK) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			scroll_q    <= 1'b0;
			copy_pend_q <= 1'b0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			copy_pend_q <= (cmd.op == OP_COPY);
			case (cmd.op)
				OP_LOAD: begin
					ptr_q    <= '0;
					scroll_q <= 1'b0;
					if (in_mode == MODE_CLEAR) begin
						col_q <= '0;
						row_q <= '0;
					end
				end
				OP_PUT: begin
					if (wrap) begin
						col_q <= '0;
						if (row_q == ROW_LAST) begin
							scroll_q <= 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				OP_COPY, OP_BLANK: begin
					ptr_q <= ptr_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item fields and result payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			mode_q  <= in_mode;
			char_q  <= in_char;
			idx_q   <= in_idx;
			rd_ok_q <= (int'(in_idx) < CELLS);
		end
		if (cmd.op == OP_COPY) begin
			copy_addr_q <= ptr_q;
		end
		if (cmd.op == OP_OUT) begin
			out_col_q    <= OCOL_W'(col_q);
			out_row_q    <= OROW_W'(row_q);
			out_char_q   <= show_cell ? rd_q[CHAR_W-1:0] : '0;
			out_attr_q   <= show_cell ? rd_q[WORD_W-1:CHAR_W] : '0;
			out_scroll_q <= scroll_q;
		end
	end

	assign show_cell = (mode_q == MODE_READ) && rd_ok_q;

	assign status.put_scroll = wrap && (row_q == ROW_LAST);
	assign status.copy_end   = (ptr_q == COPY_LAST);
	assign status.sweep_end  = (ptr_q == SWEEP_LAST);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {3'b000, out_scroll_q, out_attr_q, out_char_q, out_row_q, out_col_q};

`ifndef SYNTHESIS
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		copy_pend_q |-> cmd.op != OP_PUT && cmd.op != OP_BLANK)
		else $error("tcw_datapath: copy write-back collides with another write");

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < COLS && int'(row_q) < ROWS)
		else $error("tcw_datapath: cursor outside the screen");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_scroll_q |-> out_row_q == OROW_W'(ROWS - 1))
		else $error("tcw_datapath: scrolled result not on bottom row");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console, ROWS x COLS cells
// Put, clear and read items against a screen store with cursor and scroll.
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser: mode; tdata: char_code, cell_index
// m_*       out  m_tvalid/m_tready    tdata: cursor_col, cursor_row, cell_char,
//                                      cell_attr, did_scroll
// cfg_*     in   cfg_we               cfg_wdata: text_attribute
//
// Put and read go through accept, store access and result load for each beat.
// A scroll adds a copy phase, one cell moved per cycle through the single
// memory write port, then a write-back step, then the bottom row blanked.
// Clear blanks every cell, one cell per cycle.
// s_tready is low while an item is in work; a result waiting on m_tready holds
// only the final hand-off. Reset does not touch the screen store.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int ROWS = tcw_pkg::DEF_ROWS,
	parameter int COLS = tcw_pkg::DEF_COLS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_wdata,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// [7:0] char_code, [18:8] cell_index, rest zero
	input  wire logic [tcw_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] mode
	input  wire logic [tcw_pkg::MODE_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [6:0] cursor_col, [11:7] cursor_row, [19:12] cell_char,
	// [27:20] cell_attr, [28] did_scroll, rest zero
	output logic [tcw_pkg::M_DATA_W-1:0]      m_tdata
);
	import tcw_pkg::*;

	cmd_t  cmd;
	stat_t status;
	logic  unused_pad;

	assign unused_pad = ^s_tdata[S_DATA_W-1:CHAR_W+IDX_W];

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_mode  (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	tcw_datapath #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_mode   (s_tuser),
		.in_char   (s_tdata[CHAR_W-1:0]),
		.in_idx    (s_tdata[CHAR_W+IDX_W-1:CHAR_W]),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

>>> sim/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking bench for the text console writer
// Sends put, clear, read and unused-mode beats with random gaps and
// back-pressure. A shadow console holds the screen store, cursor and
// attribute, and every result beat is compared with its answer.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int ROWS  = DEF_ROWS;
	localparam int COLS  = DEF_COLS;
	localparam int CELLS = ROWS * COLS;
	localparam int IDX_MAX = (1 << IDX_W) - 1;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam int N_DIRECTED    = 22;
	localparam int PHASE_ITEMS   = 477;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = CELLS + 16;
	localparam int LIMIT_CYCLES  = 10_000_000;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic [2:0]        pad;
		logic              scrolled;
		logic [ATTR_W-1:0] attr;
		logic [CHAR_W-1:0] chr;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
	} console_beat_t;

	typedef struct {
		bit                is_cfg;
		logic [ATTR_W-1:0] attr_val;
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		bit                known;
		int                w_col;
		int                w_row;
		int                w_chr;
		int                w_attr;
		int                w_scroll;
	} directed_row_t;

	// cfg, attr, mode, char, index, known, col, row, char, attr, scroll
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{0, 8'h00, MODE_UNUSED,  8'hFF,        11'd2047, 1, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     8'h41,        11'd0,    1, 1, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd0,    1, 1, 0, 8'h41, 7,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd2047, 1, 1, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'hFF,        11'd2000, 1, 1, 0, 0,     0,     0},
		'{0, 8'h00, MODE_CLEAR,   8'h41,        11'd5,    1, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd1999, 1, 0, 0, 8'h20, 7,     0},
		'{1, 8'hFF, MODE_PUT,     8'h00,        11'd0,    0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     8'h00,        11'd3,    0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     8'hFF,        11'd1024, 0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     LINE_FEED,    11'd0,    1, 0, 1, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     CARRIAGE_RET, 11'd2047, 1, 0, 2, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     8'h5A,        11'd0,    0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd160,  1, 1, 2, 8'h5A, 8'hFF, 0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd1,    0, 0, 0, 0,     0,     0},
		'{1, 8'h00, MODE_PUT,     8'h00,        11'd0,    0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_PUT,     8'h7E,        11'd0,    0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd161,  0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_UNUSED,  8'h00,        11'd1999, 0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd1023, 0, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_CLEAR,   8'h00,        11'd0,    1, 0, 0, 0,     0,     0},
		'{0, 8'h00, MODE_READ,    8'h00,        11'd0,    1, 0, 0, 8'h20, 0,     0}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [ATTR_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic [MODE_W-1:0]   s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// shadow console
	logic [15:0]       screen_shadow [CELLS];
	bit                valid_cell [CELLS];
	int                cur_col = 0;
	int                cur_row = 0;
	logic [ATTR_W-1:0] attr_shadow = ATTR_RESET;

	console_beat_t expected_beats [$];
	int  mismatches    = 0;
	int  send_gap_pct  = 7;
	int  recv_idle_pct = 56;
	logic hold_req = 1'b0;
	logic hold_off = 1'b0;

	text_console_writer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic console_beat_t predict_console(input logic [MODE_W-1:0] md,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] ix);
		console_beat_t b;
		int pos;
		int i;
		b = '0;
		case (md)
			MODE_PUT: begin
				if (ch == LINE_FEED || ch == CARRIAGE_RET) begin
					cur_col = 0;
					cur_row++;
				end else begin
					pos = cur_row * COLS + cur_col;
					screen_shadow[pos] = {attr_shadow, ch};
					valid_cell[pos] = 1'b1;
					cur_col++;
					if (cur_col >= COLS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= ROWS) begin
					// scroll: move rows up, blank the bottom row
					for (i = 0; i < CELLS; i++) begin
						if (i < CELLS - COLS) begin
							screen_shadow[i] = screen_shadow[i + COLS];
							valid_cell[i] = valid_cell[i + COLS];
						end else begin
							screen_shadow[i] = {attr_shadow, BLANK_CHAR};
							valid_cell[i] = 1'b1;
						end
					end
					cur_row = ROWS - 1;
					b.scrolled = 1'b1;
				end
			end
			MODE_CLEAR: begin
				for (i = 0; i < CELLS; i++) begin
					screen_shadow[i] = {attr_shadow, BLANK_CHAR};
					valid_cell[i] = 1'b1;
				end
				cur_col = 0;
				cur_row = 0;
			end
			MODE_READ: begin
				if (ix < CELLS) begin
					b.chr  = screen_shadow[ix][7:0];
					b.attr = screen_shadow[ix][15:8];
				end
			end
			default: begin
			end
		endcase
		b.col = cur_col[OCOL_W-1:0];
		b.row = cur_row[OROW_W-1:0];
		return b;
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] md, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] ix, input bit known, input console_beat_t want);
		console_beat_t pred;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {{(S_DATA_W - IDX_W - CHAR_W){1'b0}}, ix, ch};
		do @(posedge clk); while (!s_tready);
		pred = predict_console(md, ch, ix);
		expected_beats.push_back(known ? want : pred);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	task automatic write_attr(input logic [ATTR_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr_shadow = v;
	endtask

	task automatic pick_item(output logic [MODE_W-1:0] md, output logic [CHAR_W-1:0] ch,
			output logic [IDX_W-1:0] ix);
		int r;
		r  = $urandom_range(999);
		ch = CHAR_W'($urandom_range(255));
		ix = IDX_W'($urandom_range(IDX_MAX));
		if (r < 3) begin
			md = MODE_CLEAR;
		end else if (r < 30) begin
			md = MODE_UNUSED;
		end else if (r < 200) begin
			md = MODE_READ;
			ix = IDX_W'($urandom_range(CELLS - 1));
			// never touch a cell the block has not written yet
			if ($urandom_range(4) == 0 || !valid_cell[ix])
				ix = IDX_W'(CELLS + $urandom_range(IDX_MAX - CELLS));
		end else begin
			md = MODE_PUT;
			if ($urandom_range(3) == 0)
				ch = $urandom_range(1) ? LINE_FEED : CARRIAGE_RET;
		end
	endtask

	task automatic run_phase(input int gap_pct, input int idle_pct, input bit squeeze);
		int k;
		logic [MODE_W-1:0] md;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  ix;
		send_gap_pct  = gap_pct;
		recv_idle_pct = idle_pct;
		if (squeeze)
			hold_req <= 1'b1;
		for (k = 0; k < PHASE_ITEMS; k++) begin
			if (k == PHASE_ITEMS / 2)
				write_attr(ATTR_W'($urandom_range(255)));
			pick_item(md, ch, ix);
			send_item(md, ch, ix, 1'b0, '0);
		end
		drain_results();
	endtask

	// receiver back-pressure
	initial begin
		forever begin
			@(posedge clk);
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one long receiver stall so the block backs up into its input
	initial begin
		do @(posedge clk); while (!hold_req);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		console_beat_t got;
		console_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing pending: %h", $realtime, m_tdata);
			end else begin
				want = expected_beats.pop_front();
				if (got.col !== want.col || got.row !== want.row || got.chr !== want.chr ||
						got.attr !== want.attr || got.scrolled !== want.scrolled) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch exp col %0d row %0d chr %h attr %h scr %0d,",
							" got col %0d row %0d chr %h attr %h scr %0d"},
							$realtime, want.col, want.row, want.chr, want.attr, want.scrolled,
							got.col, got.row, got.chr, got.attr, got.scrolled);
				end
			end
		end
	end

	initial begin
		int cycles;
		for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int i;
		console_beat_t want;
		for (i = 0; i < CELLS; i++) begin
			screen_shadow[i] = '0;
			valid_cell[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].is_cfg) begin
				write_attr(directed_rows[i].attr_val);
			end else begin
				want          = '0;
				want.col      = OCOL_W'(directed_rows[i].w_col);
				want.row      = OROW_W'(directed_rows[i].w_row);
				want.chr      = CHAR_W'(directed_rows[i].w_chr);
				want.attr     = ATTR_W'(directed_rows[i].w_attr);
				want.scrolled = directed_rows[i].w_scroll[0];
				send_item(directed_rows[i].mode, directed_rows[i].ch, directed_rows[i].idx,
					directed_rows[i].known, want);
			end
		end
		drain_results();

		run_phase(7, 56, 1'b0);
		run_phase(56, 7, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
